[rtl/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 80;
    localparam int MAX_ROWS_DEFAULT    = 25;

    localparam logic [6:0] COLUMNS_RESET = 7'd80;
    localparam logic [4:0] ROWS_RESET    = 5'd25;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_PUT     = 8'h0F;
    localparam logic [7:0] ATTR_BLANK   = 8'h07;
    localparam logic [15:0] BLANK_CELL  = {ATTR_BLANK, CHAR_SPACE};

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_BLANK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attribute;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } res_t;

endpackage

[rtl/text_console_cell_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Character-cell text console with a screen store and a cursor.
//
// Items enter on cmd (cmd_valid / cmd_ready) and one result item leaves on res
// (res_valid / res_ready) for every item. The config port sets the column and
// row counts in use; write it only while the block is idle.
// The screen memory has one read and one write port. A put that scrolls
// copies every row but the top one up by one row through it, then blanks
// the bottom row; a clear blanks every cell in use and homes the cursor.
// One item is worked on at a time. A finished result sits in the output
// register; the next item is taken while it waits, and the block stalls in
// its final step only if a second result is ready before the first is taken.
// After reset the block sweeps the whole store, all MAX_COLUMNS * MAX_ROWS
// cells (2000 by default), to blanks with cmd_ready low; config writes are
// taken throughout.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top
    import tcc_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
    parameter int MAX_ROWS    = MAX_ROWS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CXW   = (CW > 7) ? CW : 7;
    localparam int RXW   = (RW > 5) ? RW : 5;
    localparam int IXW   = (DW > 11) ? DW : 11;

    state_t         state_reg, state_next;
    logic [6:0]     cols_cfg_reg;
    logic [4:0]     rows_cfg_reg;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [DW-1:0]  ptr_reg, ptr_next;
    logic [DW-1:0]  end_reg, end_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  waddr_reg, waddr_next;
    cmd_t           cmd_reg, cmd_next;
    logic [7:0]     chr_reg, chr_next;
    logic [7:0]     attr_reg, attr_next;
    logic           res_valid_reg, res_valid_next;
    res_t           res_reg, res_next;

    logic [15:0]    mem [DEPTH];
    logic [15:0]    rdata_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [15:0]    mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;

    logic [CW-1:0]  eff_cols;
    logic [RW-1:0]  eff_rows;
    logic [DW-1:0]  area;
    logic [DW-1:0]  last;
    logic [RW-1:0]  sat_row;
    logic [CW-1:0]  sat_col;
    logic [DW-1:0]  put_addr;

    always_comb
    begin
        if (cols_cfg_reg == 7'd0)
            eff_cols = CW'(1);
        else if (CXW'(cols_cfg_reg) > CXW'(MAX_COLUMNS))
            eff_cols = CW'(MAX_COLUMNS);
        else
            eff_cols = CW'(cols_cfg_reg);

        if (rows_cfg_reg == 5'd0)
            eff_rows = RW'(1);
        else if (RXW'(rows_cfg_reg) > RXW'(MAX_ROWS))
            eff_rows = RW'(MAX_ROWS);
        else
            eff_rows = RW'(rows_cfg_reg);
    end

    assign area = DW'(eff_cols) * DW'(eff_rows);
    assign last = DW'(eff_rows - RW'(1)) * DW'(eff_cols);
    assign sat_row = (row_reg >= eff_rows) ? eff_rows - RW'(1) : row_reg;
    assign sat_col = (col_reg >= eff_cols) ? eff_cols - CW'(1) : col_reg;
    assign put_addr = DW'(sat_row) * DW'(eff_cols) + DW'(sat_col);

    always_comb
    begin
        logic [RW-1:0] nrow;
        logic [CW-1:0] ncol;

        nrow           = row_reg;
        ncol           = col_reg;
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        pend_next      = 1'b0;
        waddr_next     = waddr_reg;
        cmd_next       = cmd_reg;
        chr_next       = chr_reg;
        attr_next      = attr_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg[AW-1:0];
        mem_wdata      = BLANK_CELL;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg[AW-1:0];

        if (pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = waddr_reg;
            mem_wdata = rdata_reg;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = BLANK_CELL;
                if (ptr_reg == DW'(DEPTH - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + DW'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                chr_next   = 8'd0;
                attr_next  = 8'd0;
                state_next = ST_FINISH;
                case (cmd_reg.opcode)
                    OP_PUT:
                    begin
                        if (cmd_reg.char_code == CHAR_NEWLINE)
                        begin
                            ncol = '0;
                            nrow = sat_row + RW'(1);
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = put_addr[AW-1:0];
                            mem_wdata = {ATTR_PUT, cmd_reg.char_code};
                            ncol      = sat_col + CW'(1);
                            nrow      = sat_row;
                        end
                        if (ncol >= eff_cols)
                        begin
                            ncol = '0;
                            nrow = nrow + RW'(1);
                        end
                        if (nrow >= eff_rows)
                        begin
                            nrow       = eff_rows - RW'(1);
                            ptr_next   = '0;
                            end_next   = last;
                            state_next = ST_SCROLL;
                        end
                        row_next = nrow;
                        col_next = ncol;
                    end
                    OP_CLEAR:
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        ptr_next   = '0;
                        end_next   = area;
                        state_next = ST_BLANK;
                    end
                    OP_READ:
                    begin
                        if (IXW'(cmd_reg.cell_index) < IXW'(area))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(cmd_reg.cell_index);
                            state_next = ST_READ_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                chr_next   = rdata_reg[7:0];
                attr_next  = rdata_reg[15:8];
                state_next = ST_FINISH;
            end
            ST_SCROLL:
            begin
                if (ptr_reg < end_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(ptr_reg + DW'(eff_cols));
                    pend_next  = 1'b1;
                    waddr_next = ptr_reg[AW-1:0];
                    ptr_next   = ptr_reg + DW'(1);
                end
                else if (!pend_reg)
                begin
                    end_next   = area;
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = BLANK_CELL;
                if (ptr_reg + DW'(1) == end_reg)
                    state_next = ST_FINISH;
                else
                    ptr_next = ptr_reg + DW'(1);
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next          = 1'b1;
                    res_next.cell_char      = chr_reg;
                    res_next.cell_attribute = attr_reg;
                    res_next.cursor_row     = 5'(row_reg);
                    res_next.cursor_col     = 7'(col_reg);
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            ptr_reg       <= '0;
            end_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ptr_reg       <= ptr_next;
            end_reg       <= end_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg <= waddr_next;
        cmd_reg   <= cmd_next;
        chr_reg   <= chr_next;
        attr_reg  <= attr_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= COLUMNS_RESET;
            rows_cfg_reg <= ROWS_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_COLUMNS: cols_cfg_reg <= cfg_data;
                REG_ROWS:    rows_cfg_reg <= cfg_data[4:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_blank_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLANK) |-> !pend_reg)
        else $error("copy write still pending during blank fill");

    a_blank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLANK) |-> (ptr_reg < end_reg))
        else $error("blank fill pointer past end");

    a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ_WAIT) |-> ($past(state_reg) == ST_EXEC))
        else $error("read wait entered without a read");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish step");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console cell writer. A queue of command
// items, directed first and then random phases over many screen geometries,
// feeds a valid/ready driver. Each accepted item runs through a behavioural
// console model that keeps its own screen, cursor and geometry. A monitor
// checks every reply field against the oldest prediction. Geometry changes
// only once the console has gone quiet.
// ----------------------------------------------------------------------------
module testbench;

    import tcc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STORE_CELLS = MAX_COLUMNS_DEFAULT * MAX_ROWS_DEFAULT;
    localparam int         CYCLE_LIMIT = 1000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    cmd_t       cmd = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    res_t       res;
    logic       cfg_write_en = 1'b0;
    logic       cfg_index = REG_COLUMNS;
    logic [6:0] cfg_data = '0;

    cmd_t        queued_commands[$];
    res_t        predicted_replies[$];
    logic [15:0] screen_store [0:STORE_CELLS-1];
    int unsigned cursor_line;
    int unsigned cursor_column;
    logic [6:0]  columns_reg;
    logic [4:0]  rows_reg;
    bit          idling_enabled = 1'b1;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned reply_stall = 0;

    text_console_cell_writer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned active_columns();
        if (columns_reg == 0)
            return 1;
        if (columns_reg > MAX_COLUMNS_DEFAULT)
            return MAX_COLUMNS_DEFAULT;
        return columns_reg;
    endfunction

    function automatic int unsigned active_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > MAX_ROWS_DEFAULT)
            return MAX_ROWS_DEFAULT;
        return rows_reg;
    endfunction

    function automatic void scroll_screen(int unsigned ncols, int unsigned nrows);
        int unsigned bottom_base;
        bottom_base = (nrows - 1) * ncols;
        for (int unsigned i = 0; i < bottom_base; i++)
            screen_store[i] = screen_store[i + ncols];
        for (int unsigned i = 0; i < ncols; i++)
            screen_store[bottom_base + i] = BLANK_CELL;
    endfunction

    function automatic res_t apply_command(cmd_t c);
        res_t        reply;
        int unsigned ncols;
        int unsigned nrows;
        logic [15:0] stored_cell;
        ncols = active_columns();
        nrows = active_rows();
        reply = '0;
        case (c.opcode)
            OP_PUT:
            begin
                if (cursor_line >= nrows)
                    cursor_line = nrows - 1;
                if (cursor_column >= ncols)
                    cursor_column = ncols - 1;
                if (c.char_code == CHAR_NEWLINE)
                begin
                    cursor_column = 0;
                    cursor_line++;
                end
                else
                begin
                    screen_store[cursor_line * ncols + cursor_column] = {ATTR_PUT, c.char_code};
                    cursor_column++;
                end
                if (cursor_column >= ncols)
                begin
                    cursor_column = 0;
                    cursor_line++;
                end
                if (cursor_line >= nrows)
                begin
                    scroll_screen(ncols, nrows);
                    cursor_line = nrows - 1;
                end
            end
            OP_CLEAR:
            begin
                for (int unsigned i = 0; i < ncols * nrows; i++)
                    screen_store[i] = BLANK_CELL;
                cursor_line = 0;
                cursor_column = 0;
            end
            OP_READ:
            begin
                if (c.cell_index < ncols * nrows)
                begin
                    stored_cell = screen_store[c.cell_index];
                    reply.cell_char = stored_cell[7:0];
                    reply.cell_attribute = stored_cell[15:8];
                end
            end
            default: ;
        endcase
        reply.cursor_row = cursor_line[4:0];
        reply.cursor_col = cursor_column[6:0];
        return reply;
    endfunction

    function automatic int unsigned gap_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 2);
        if (pick < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic cmd_t random_command();
        cmd_t        c;
        int unsigned pick;
        int unsigned area;
        area = active_columns() * active_rows();
        pick = $urandom_range(0, 99);
        c.char_code = 8'($urandom_range(0, 255));
        c.cell_index = 11'($urandom_range(0, 2047));
        if (pick < 60)
        begin
            c.opcode = OP_PUT;
            if ($urandom_range(0, 99) < 12)
                c.char_code = CHAR_NEWLINE;
        end
        else if (pick < 88)
        begin
            c.opcode = OP_READ;
            if ($urandom_range(0, 99) < 85)
                c.cell_index = 11'($urandom_range(0, area - 1));
        end
        else if (pick < 94)
            c.opcode = OP_CLEAR;
        else
            c.opcode = OP_UNUSED;
        return c;
    endfunction

    task automatic push_command(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
        cmd_t c;
        c.opcode = op;
        c.char_code = ch;
        c.cell_index = idx;
        queued_commands.push_back(c);
    endtask

    task automatic wait_until_quiet();
        do
            @(negedge clk);
        while (queued_commands.size() != 0 || cmd_valid || predicted_replies.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [6:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_COLUMNS)
            columns_reg = value;
        else
            rows_reg = value[4:0];
    endtask

    task automatic run_phase(logic [6:0] cols_value, logic [6:0] rows_value, int unsigned count);
        wait_until_quiet();
        write_register(REG_COLUMNS, cols_value);
        write_register(REG_ROWS, rows_value);
        idling_enabled = ($urandom_range(0, 3) != 0);
        @(negedge clk);
        for (int unsigned i = 0; i < count; i++)
            queued_commands.push_back(random_command());
    endtask

    task automatic check_field(string field_name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %h, got %h at %0t", field_name, want, got, $time);
        end
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && cmd_ready)
                predicted_replies.push_back(apply_command(cmd));
            if (!cmd_valid || cmd_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    cmd_valid <= 1'b0;
                end
                else if (queued_commands.size() != 0)
                begin
                    cmd <= queued_commands.pop_front();
                    cmd_valid <= 1'b1;
                    send_gap <= idling_enabled ? gap_length() : 0;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // reply monitor
    always @(posedge clk)
    begin
        res_t want;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected reply %h at %0t", res, $time);
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    check_field("cell_char", want.cell_char, res.cell_char);
                    check_field("cell_attribute", want.cell_attribute, res.cell_attribute);
                    check_field("cursor_row", 8'(want.cursor_row), 8'(res.cursor_row));
                    check_field("cursor_col", 8'(want.cursor_col), 8'(res.cursor_col));
                end
            end
            if (reply_stall > 0)
            begin
                reply_stall <= reply_stall - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if (idling_enabled && $urandom_range(0, 5) == 0)
                    reply_stall <= gap_length();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < STORE_CELLS; i++)
            screen_store[i] = BLANK_CELL;
        cursor_line = 0;
        cursor_column = 0;
        columns_reg = COLUMNS_RESET;
        rows_reg = ROWS_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_register(REG_COLUMNS, COLUMNS_RESET);
        write_register(REG_ROWS, {2'b00, ROWS_RESET});
        @(negedge clk);
        push_command(OP_READ, 8'h00, 11'd0);
        push_command(OP_READ, 8'hFF, 11'd1999);
        push_command(OP_READ, 8'h00, 11'd2047);
        push_command(OP_UNUSED, 8'hFF, 11'h7FF);
        push_command(OP_PUT, 8'h41, 11'd0);
        push_command(OP_PUT, 8'hFF, 11'h7FF);
        push_command(OP_PUT, 8'h00, 11'd0);
        push_command(OP_PUT, CHAR_NEWLINE, 11'd0);
        push_command(OP_READ, 8'h00, 11'd1);
        push_command(OP_READ, 8'h00, 11'd80);
        push_command(OP_CLEAR, 8'h00, 11'd0);
        push_command(OP_READ, 8'h00, 11'd0);

        // tiny screen: wrap at the column limit, scroll on put and on newline
        wait_until_quiet();
        write_register(REG_COLUMNS, 7'd3);
        write_register(REG_ROWS, 7'd2);
        @(negedge clk);
        for (int i = 1; i <= 6; i++)
            push_command(OP_PUT, 8'(8'h30 + i), 11'd0);
        push_command(OP_PUT, CHAR_NEWLINE, 11'd0);
        push_command(OP_READ, 8'h00, 11'd0);
        push_command(OP_READ, 8'h00, 11'd5);
        push_command(OP_READ, 8'h00, 11'd6);

        run_phase(7'd1, 7'd1, 60);
        run_phase(7'd5, 7'd4, 100);
        run_phase(7'd0, 7'd0, 40);
        run_phase(7'd8, 7'd6, 100);
        run_phase(7'd80, 7'd1, 60);
        run_phase(7'd1, 7'd25, 60);
        run_phase(7'd3, 7'd7, 100);
        run_phase(7'd127, 7'd2, 40);
        run_phase(7'd4, 7'h7F, 60);
        run_phase(7'd10, 7'd10, 100);
        run_phase(7'd80, 7'd25, 30);

        wait_until_quiet();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
